// File: sv/cartridge_bank_controller_assert.svh
// assertion macros shared by the bank controller
`ifndef CARTRIDGE_BANK_CONTROLLER_ASSERT_SVH
`define CARTRIDGE_BANK_CONTROLLER_ASSERT_SVH

// same-cycle implication
`define CBC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cbc check failed");

// next-cycle implication
`define CBC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cbc check failed");

`endif

// File: sv/cbc_pkg.sv
package cbc_pkg;

  localparam int ROM_ADDR_BITS = 21;
  localparam int ROM_FULL_W    = 22;
  localparam logic [ROM_FULL_W-1:0] ROM_MASK =
    ROM_FULL_W'((64'd1 << ROM_ADDR_BITS) - 64'd1);

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_MBC1 = 2'd1,
    KIND_MBC2 = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    TGT_NONE = 2'd0,
    TGT_ROM  = 2'd1,
    TGT_RAM  = 2'd2
  } target_t;

  localparam logic ACT_READ  = 1'b0;
  localparam logic ACT_WRITE = 1'b1;

  typedef struct packed {
    logic        action;
    logic [15:0] bus_address;
    logic [7:0]  bus_data;
  } access_t;

  typedef struct packed {
    logic [1:0]  target;
    logic [20:0] mem_address;
    logic        write_strobe;
    logic [7:0]  write_value;
  } result_t;

endpackage

// File: sv/cbc_in_if.sv
interface cbc_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [15:0] bus_address;
  logic [7:0]  bus_data;

  modport source (output valid, output action, output bus_address, output bus_data,
                  input ready);
  modport sink (input valid, input action, input bus_address, input bus_data,
                output ready);
endinterface

// File: sv/cbc_out_if.sv
interface cbc_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  target;
  logic [20:0] mem_address;
  logic        write_strobe;
  logic [7:0]  write_value;

  modport source (output valid, output target, output mem_address,
                  output write_strobe, output write_value, input ready);
  modport sink (input valid, input target, input mem_address,
                input write_strobe, input write_value, output ready);
endinterface

// File: sv/cbc_cfg_if.sv
interface cbc_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] controller_type;

  modport source (output valid, output controller_type, input ready);
  modport sink (input valid, input controller_type, output ready);
endinterface

// File: sv/cbc_bank.sv
module cbc_bank (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [1:0]       ctype,
  input  logic             fire,
  input  cbc_pkg::access_t acc,
  output cbc_pkg::result_t res
);

  logic [7:0] rom_bank_r, rom_bank_nxt;
  logic [1:0] ram_bank_r, ram_bank_nxt;
  logic       ram_en_r, ram_en_nxt;
  logic       mode_r, mode_nxt;

  cbc_pkg::kind_t kind;
  logic [15:0] a;
  logic [7:0]  d;
  logic        is_wr;
  logic        in_ram;
  logic [cbc_pkg::ROM_FULL_W-1:0] rom_full;
  logic [cbc_pkg::ROM_FULL_W-1:0] rom_masked;
  logic [4:0]  lo5;
  logic [3:0]  lo4;
  logic        en_hit;

  always_comb begin
    case (ctype)
      cbc_pkg::KIND_MBC1: kind = cbc_pkg::KIND_MBC1;
      cbc_pkg::KIND_MBC2: kind = cbc_pkg::KIND_MBC2;
      default:            kind = cbc_pkg::KIND_NONE;
    endcase
  end

  assign a      = acc.bus_address;
  assign d      = acc.bus_data;
  assign is_wr  = (acc.action == cbc_pkg::ACT_WRITE);
  assign in_ram = (a[15:13] == 3'b101);
  assign lo5    = (d[4:0] == 5'd0) ? 5'd1 : d[4:0];
  assign lo4    = (d[3:0] == 4'd0) ? 4'd1 : d[3:0];
  assign en_hit = (d[3:0] == 4'hA) || (d == 8'd0);

  // bank register updates on writes to the low half
  always_comb begin
    rom_bank_nxt = rom_bank_r;
    ram_bank_nxt = ram_bank_r;
    ram_en_nxt   = ram_en_r;
    mode_nxt     = mode_r;
    if (!a[15] && is_wr) begin
      case (a[14:13])
        2'd0: begin
          if ((kind == cbc_pkg::KIND_MBC1 ||
               (kind == cbc_pkg::KIND_MBC2 && !a[8])) && en_hit) begin
            ram_en_nxt = (d[3:0] == 4'hA);
          end
        end
        2'd1: begin
          if (kind == cbc_pkg::KIND_MBC1) begin
            rom_bank_nxt = {rom_bank_r[7:5], lo5};
          end else if (kind == cbc_pkg::KIND_MBC2) begin
            rom_bank_nxt = {4'd0, lo4};
          end
        end
        2'd2: begin
          if (kind == cbc_pkg::KIND_MBC1) begin
            if (mode_r) begin
              ram_bank_nxt = 2'd0;
              rom_bank_nxt = {1'b0, d[1:0],
                              (rom_bank_r[4:0] == 5'd0) ? 5'd1 : rom_bank_r[4:0]};
            end else begin
              ram_bank_nxt = d[1:0];
            end
          end
        end
        default: begin
          if (kind == cbc_pkg::KIND_MBC1) begin
            if (d[0]) begin
              ram_bank_nxt = 2'd0;
              mode_nxt     = 1'b0;
            end else begin
              mode_nxt = 1'b1;
            end
          end
        end
      endcase
    end
  end

  // address mapping
  always_comb begin
    if (a[14] && kind != cbc_pkg::KIND_NONE) begin
      rom_full = {rom_bank_r, a[13:0]};
    end else begin
      rom_full = {6'd0, a};
    end
    rom_masked = rom_full & cbc_pkg::ROM_MASK;

    res = '0;
    if (!a[15]) begin
      if (!is_wr) begin
        res.target      = cbc_pkg::TGT_ROM;
        res.mem_address = rom_masked[20:0];
      end
    end else if (in_ram) begin
      res.target = cbc_pkg::TGT_RAM;
      if (kind == cbc_pkg::KIND_MBC2) begin
        res.mem_address = {12'd0, a[8:0]};
      end else begin
        res.mem_address = {6'd0, ram_bank_r, a[12:0]};
      end
      if (is_wr && ram_en_r &&
          (kind == cbc_pkg::KIND_MBC1 ||
           (kind == cbc_pkg::KIND_MBC2 && a[12:9] == 4'd0))) begin
        res.write_strobe = 1'b1;
        res.write_value  = d;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rom_bank_r <= 8'd1;
      ram_bank_r <= 2'd0;
      ram_en_r   <= 1'b0;
      mode_r     <= 1'b1;
    end else if (fire) begin
      rom_bank_r <= rom_bank_nxt;
      ram_bank_r <= ram_bank_nxt;
      ram_en_r   <= ram_en_nxt;
      mode_r     <= mode_nxt;
    end
  end

endmodule

// File: sv/cartridge_bank_controller.sv
// channel   dir  beat contents
// in_bus    in   action, bus_address, bus_data
// out_bus   out  target, mem_address, write_strobe, write_value
// cfg_bus   in   controller_type
//
// two register stages: input register, then result register; one beat per cycle while out_bus does not stall
// each input beat passes the input register, then the result register, to become a result beat
// bank state updates as a beat moves from the input register to the result register
// rst_n is synchronous: banks, enable, mode and controller type return to defaults
// a stalled result holds; a new input beat is still taken while the input register is empty
`include "cartridge_bank_controller_assert.svh"

module cartridge_bank_controller (
  input  logic          clk,
  input  logic          rst_n,
  cbc_in_if.sink        in_bus,
  cbc_out_if.source     out_bus,
  cbc_cfg_if.sink       cfg_bus
);

  logic [1:0]       ctype_r;
  logic             s1_valid_r;
  cbc_pkg::access_t s1_acc_r;
  logic             out_valid_r;
  cbc_pkg::result_t out_res_r;
  cbc_pkg::result_t res;
  logic             s2_ready;
  logic             s1_fire;
  logic             in_fire;

  assign cfg_bus.ready = 1'b1;

  assign s2_ready     = !out_valid_r || out_bus.ready;
  assign s1_fire      = s1_valid_r && s2_ready;
  assign in_bus.ready = !s1_valid_r || s2_ready;
  assign in_fire      = in_bus.valid && in_bus.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctype_r <= cbc_pkg::KIND_NONE;
    end else if (cfg_bus.valid && cfg_bus.ready) begin
      ctype_r <= cfg_bus.controller_type;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_acc_r.action      <= in_bus.action;
      s1_acc_r.bus_address <= in_bus.bus_address;
      s1_acc_r.bus_data    <= in_bus.bus_data;
    end
  end

  cbc_bank u_bank (
    .clk   (clk),
    .rst_n (rst_n),
    .ctype (ctype_r),
    .fire  (s1_fire),
    .acc   (s1_acc_r),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_res_r <= res;
    end
  end

  assign out_bus.valid        = out_valid_r;
  assign out_bus.target       = out_res_r.target;
  assign out_bus.mem_address  = out_res_r.mem_address;
  assign out_bus.write_strobe = out_res_r.write_strobe;
  assign out_bus.write_value  = out_res_r.write_value;

  `CBC_ASSERT_NOW(a_strobe_ram, out_valid_r && out_res_r.write_strobe, out_res_r.target == cbc_pkg::TGT_RAM)
  `CBC_ASSERT_NOW(a_none_zero, out_valid_r && out_res_r.target == cbc_pkg::TGT_NONE, out_res_r.mem_address == 21'd0 && !out_res_r.write_strobe)
  `CBC_ASSERT_NOW(a_stall_full, !in_bus.ready, s1_valid_r && out_valid_r && !out_bus.ready)
  `CBC_ASSERT_NEXT(a_pass_out, s1_fire, out_valid_r)

endmodule
